// File: sv/cit_pkg.sv
// shared constants, request codes and command type for the channel id table
package cit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = SLOT_W + 1;
  localparam int ID_W        = 32;
  localparam int COUNT_W     = 7;
  localparam int COUNT_MAX   = 127;

  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_BIND  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;
  localparam logic [1:0] REQ_COUNT = 2'd3;

  // classified request as it travels from front to back
  typedef struct packed {
    logic [1:0]        req;
    logic [SLOT_W-1:0] slot;
    logic              id_ok;
  } cmd_t;

endpackage

// File: sv/cit_front.sv
// front end: takes items and turns a lookup id into a candidate slot
module cit_front import cit_pkg::*; (
  input  logic            start,
  input  logic            full,
  input  logic [1:0]      req_type,
  input  logic [ID_W-1:0] lookup_id,
  output logic            push,
  output cmd_t            cmd
);

  logic [ID_W-1:0] id_m1;

  // ids are handed out as slot + 1, so slot = id - 1 when it fits
  assign id_m1 = lookup_id - ID_W'(1);

  assign push      = start && !full;
  assign cmd.req   = req_type;
  assign cmd.slot  = id_m1[SLOT_W-1:0];
  assign cmd.id_ok = (lookup_id != '0) && (id_m1[ID_W-1:SLOT_W] == '0);

endmodule

// File: sv/cit_queue.sv
// two-entry command queue between front and back
module cit_queue import cit_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/cit_back.sv
// back end: live marks, fill and live counters, registered result
module cit_back import cit_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               pop,
  output logic               res_valid,
  output logic               res_status,
  output logic [ID_W-1:0]    res_id,
  output logic [COUNT_W-1:0] res_count
);

  logic [TABLE_DEPTH-1:0] live_r, live_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [FILL_W-1:0]      nlive_r, nlive_nxt;
  logic                   valid_r;
  logic                   status_r, status_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   hit;
  logic                   has_room;

  assign pop      = cmd_valid;
  assign has_room = (CMP_W'(fill_r) < CMP_W'(TABLE_DEPTH));
  // slot must be one already opened and still live
  assign hit      = cmd.id_ok && (CMP_W'(cmd.slot) < CMP_W'(fill_r)) && live_r[cmd.slot];

  always_comb begin
    live_nxt   = live_r;
    fill_nxt   = fill_r;
    nlive_nxt  = nlive_r;
    status_nxt = 1'b1;
    id_nxt     = '0;
    count_nxt  = '0;
    if (cmd_valid) begin
      case (cmd.req)
        REQ_OPEN: begin
          if (has_room) begin
            live_nxt[fill_r[SLOT_W-1:0]] = 1'b1;
            fill_nxt   = fill_r + FILL_W'(1);
            nlive_nxt  = nlive_r + FILL_W'(1);
            status_nxt = 1'b0;
            id_nxt     = ID_W'(fill_r) + ID_W'(1);
          end
        end
        REQ_BIND: begin
          if (hit) begin
            status_nxt = 1'b0;
          end
        end
        REQ_CLOSE: begin
          if (hit) begin
            live_nxt[cmd.slot] = 1'b0;
            nlive_nxt  = nlive_r - FILL_W'(1);
            status_nxt = 1'b0;
          end
        end
        REQ_COUNT: begin
          status_nxt = 1'b0;
          count_nxt  = (32'(nlive_r) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : COUNT_W'(nlive_r);
        end
        default: begin
          status_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      fill_r  <= '0;
      nlive_r <= '0;
      valid_r <= 1'b0;
    end else begin
      live_r  <= live_nxt;
      fill_r  <= fill_nxt;
      nlive_r <= nlive_nxt;
      valid_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    id_r     <= id_nxt;
    count_r  <= count_nxt;
  end

  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_id     = id_r;
  assign res_count  = count_r;

endmodule

// File: sv/channel_id_table.sv
// top level of the channel id table: front, command queue and back
//
// An item is taken on a rising edge with start high and busy low, and its
// result shows on the out_ ports for exactly one cycle with out_valid high,
// once it has passed the command queue and the result register; the
// receiver cannot hold results off, so results simply stream out in request
// order. The back end retires one queued request per cycle, so a new item
// may be given every cycle and busy, which reports a full two-entry command
// queue, stays low in normal use. There is no clearing pass after reset.
// Slots are handed out in order and never reused, so the local id of slot s
// is always s + 1; bind and close therefore check one slot directly instead
// of searching the table. The kind, window and peer id fields are taken with
// the item but no request ever reads them back, so they are not kept.
module channel_id_table import cit_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [1:0]         in_chan_kind,
  input  logic signed [31:0] in_window_request,
  input  logic [ID_W-1:0]    in_lookup_id,
  input  logic [ID_W-1:0]    in_peer_id,
  output logic               out_valid,
  output logic               out_status,
  output logic [ID_W-1:0]    out_assigned_id,
  output logic [COUNT_W-1:0] out_open_count
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_not_empty;
  cmd_t q_head;
  logic pop;

  // front: decode the request and map the lookup id onto a slot
  cit_front u_front (
    .start     (start),
    .full      (q_full),
    .req_type  (in_req_type),
    .lookup_id (in_lookup_id),
    .push      (push),
    .cmd       (push_cmd)
  );

  // short command queue between front and back; the back end never holds it off
  cit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: apply the request to the live marks and counters
  cit_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (q_head),
    .pop        (pop),
    .res_valid  (out_valid),
    .res_status (out_status),
    .res_id     (out_assigned_id),
    .res_count  (out_open_count)
  );

  assign busy = q_full;

  // every taken item yields its result once it has passed the queue and result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after item was taken");

  // a nonzero id only comes with a successful result
  a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_assigned_id != '0)) |-> !out_status)
    else $error("assigned id on a failed result");

  // a nonzero count only on a shown, successful result, and never with an id
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_open_count != '0) |-> (out_valid && !out_status && (out_assigned_id == '0)))
    else $error("open count outside a count result");

endmodule
